// ----- rtl/bdeque_pkg.sv -----
package bdeque_pkg;

    // built storage depth
    localparam int BDEQUE_CAPACITY = 16;

    // field widths
    localparam int WORD_W  = 32;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;
    localparam int LIMIT_W = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_DUMP         = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE_END   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INSERT_FRONT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE_FRONT = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [WORD_W-1:0] value;
    } bdeque_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic                     has_item;
        logic signed [WORD_W-1:0] item;
        logic                     last;
    } bdeque_out_t;

endpackage

// ----- rtl/bdeque_ram.sv -----
module bdeque_ram #(
    parameter int DEPTH  = bdeque_pkg::BDEQUE_CAPACITY,
    parameter int ADDR_W = 4
) (
    input  logic                            aclk,
    input  logic                            we,
    input  logic [ADDR_W-1:0]               waddr,
    input  logic [bdeque_pkg::WORD_W-1:0]   wdata,
    input  logic                            re,
    input  logic [ADDR_W-1:0]               raddr,
    output logic [bdeque_pkg::WORD_W-1:0]   rdata
);
    import bdeque_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bounded_array_deque.sv -----
// sequence: a word's single result is registered in S_RESP, except a dump, which gives one
//   result per entry from S_DUMP (a single result in S_RESP when the list is empty)
// throughput: one word at a time; insert at front steps S_UP_RD/S_UP_WR and remove at front
//   S_DN_RD/S_DN_WR, shifting entries through the entry memory's read and write ports before
//   the response when the list takes them; every word also waits out any output stall
// reset: list empty, limit at full capacity; entry memory is not cleared
module bounded_array_deque #(
    parameter int CAPACITY = bdeque_pkg::BDEQUE_CAPACITY
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [bdeque_pkg::LIMIT_W-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  bdeque_pkg::bdeque_in_t           s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output bdeque_pkg::bdeque_out_t          m_data
);
    import bdeque_pkg::*;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LIM_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_DUMP,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [LIM_W-1:0]   limit_reg;
    logic [ADDR_W-1:0]  idx_reg;
    logic [WORD_W-1:0]  val_reg;
    logic [STAT_W-1:0]  status_reg;
    logic               m_valid_reg;
    bdeque_out_t        m_data_reg;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [WORD_W-1:0]  mem_rdata;

    logic               accept;
    logic               out_free;
    logic               is_full;
    logic               is_empty;
    logic               at_tail;
    logic [ADDR_W-1:0]  idx_inc;
    logic [ADDR_W-1:0]  idx_dec;
    logic [ADDR_W-1:0]  count_addr;

    bdeque_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk   (aclk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .re     (mem_re),
        .raddr  (mem_raddr),
        .rdata  (mem_rdata)
    );

    // handshake and shared flags
    assign s_ready    = (state_reg == S_IDLE);
    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    assign is_full    = (LIM_W'(count_reg) >= limit_reg) || (count_reg == CNT_W'(CAPACITY));
    assign is_empty   = (count_reg == '0);
    assign at_tail    = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign idx_inc    = idx_reg + ADDR_W'(1);
    assign idx_dec    = idx_reg - ADDR_W'(1);
    assign count_addr = count_reg[ADDR_W-1:0];

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = idx_inc;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_data.cmd == CMD_APPEND && !is_full) begin
                        mem_we    = 1'b1;
                        mem_waddr = count_addr;
                        mem_wdata = s_data.value;
                    end
                    if (s_data.cmd == CMD_DUMP && !is_empty) begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                    end
                end
            end
            S_DUMP: begin
                if (out_free && !at_tail) begin
                    mem_re = 1'b1;
                end
            end
            S_UP_RD: begin
                if (idx_reg == '0) begin
                    mem_we    = 1'b1;
                    mem_wdata = val_reg;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_dec;
                end
            end
            S_UP_WR: begin
                mem_we = 1'b1;
            end
            S_DN_RD: begin
                if (!at_tail) begin
                    mem_re = 1'b1;
                end
            end
            S_DN_WR: begin
                mem_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // sequencer, list state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            limit_reg   <= LIM_W'(CAPACITY);
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                limit_reg <= LIM_W'(cfg_wdata);
            end
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        val_reg    <= s_data.value;
                        status_reg <= ST_OK;
                        idx_reg    <= '0;
                        state_reg  <= S_RESP;
                        unique case (s_data.cmd)
                            CMD_DUMP: begin
                                if (!is_empty) begin
                                    state_reg <= S_DUMP;
                                end
                            end
                            CMD_APPEND: begin
                                if (is_full) begin
                                    status_reg <= ST_FULL;
                                end else begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                            end
                            CMD_REMOVE_END: begin
                                if (is_empty) begin
                                    status_reg <= ST_EMPTY;
                                end else begin
                                    count_reg <= count_reg - CNT_W'(1);
                                end
                            end
                            CMD_INSERT_FRONT: begin
                                if (is_full) begin
                                    status_reg <= ST_FULL;
                                end else begin
                                    idx_reg   <= count_addr;
                                    state_reg <= S_UP_RD;
                                end
                            end
                            CMD_REMOVE_FRONT: begin
                                if (is_empty) begin
                                    status_reg <= ST_EMPTY;
                                end else begin
                                    state_reg <= S_DN_RD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        m_valid_reg         <= 1'b1;
                        m_data_reg.status   <= status_reg;
                        m_data_reg.has_item <= 1'b0;
                        m_data_reg.item     <= '0;
                        m_data_reg.last     <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end
                S_DUMP: begin
                    if (out_free) begin
                        m_valid_reg         <= 1'b1;
                        m_data_reg.status   <= ST_OK;
                        m_data_reg.has_item <= 1'b1;
                        m_data_reg.item     <= mem_rdata;
                        m_data_reg.last     <= at_tail;
                        if (at_tail) begin
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg <= idx_inc;
                        end
                    end
                end
                S_UP_RD: begin
                    if (idx_reg == '0) begin
                        count_reg <= count_reg + CNT_W'(1);
                        state_reg <= S_RESP;
                    end else begin
                        state_reg <= S_UP_WR;
                    end
                end
                S_UP_WR: begin
                    idx_reg   <= idx_dec;
                    state_reg <= S_UP_RD;
                end
                S_DN_RD: begin
                    if (at_tail) begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= S_RESP;
                    end else begin
                        state_reg <= S_DN_WR;
                    end
                end
                S_DN_WR: begin
                    idx_reg   <= idx_inc;
                    state_reg <= S_DN_RD;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- tb/tb_bounded_array_deque.sv -----
`timescale 1ns / 1ps

module tb_bounded_array_deque;
    import bdeque_pkg::*;

    localparam int CAP            = BDEQUE_CAPACITY;
    // longest idle tail: insert at front on a list one short of full plus margin
    localparam int SETTLE_CYCLES  = 2 * CAP + 8;
    localparam int LONG_HOLD      = 150;
    localparam int WATCHDOG_LIMIT = 2000;

    // codes the block treats as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_MD = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam logic signed [WORD_W-1:0] WORD_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN  = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_ONES = -32'sd1;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [LIMIT_W-1:0]   cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    bdeque_in_t           s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    bdeque_out_t          m_data;

    bounded_array_deque #(
        .CAPACITY(CAP)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // predicted list contents and limit
    logic signed [WORD_W-1:0] deque_cells [CAP];
    int unsigned              deque_count = 0;
    logic [LIMIT_W-1:0]       deque_limit = LIMIT_W'(CAP);

    bdeque_in_t  pending_words [$];
    bdeque_out_t expected_results [$];

    int          mismatch_count = 0;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    int unsigned recv_hold = 0;
    int          hold_ask = 0;
    int          hold_done = 0;
    bit          send_idle_on = 1'b1;
    bit          recv_idle_on = 1'b1;
    int          quiet_cycles = 0;

    // apply one command word to the predicted list and queue its results
    function automatic void apply_deque_command(bdeque_in_t w);
        int unsigned room;
        int          i;
        bdeque_out_t r;
        room = (deque_limit > CAP) ? CAP : deque_limit;
        r = '0;
        r.status = ST_OK;
        r.last = 1'b1;
        case (w.cmd)
            CMD_DUMP: begin
                if (deque_count == 0) begin
                    expected_results.push_back(r);
                end else begin
                    for (i = 0; i < deque_count; i++) begin
                        r.has_item = 1'b1;
                        r.item = deque_cells[i];
                        r.last = (i == deque_count - 1);
                        expected_results.push_back(r);
                    end
                end
            end
            CMD_APPEND: begin
                if (deque_count >= room) begin
                    r.status = ST_FULL;
                end else begin
                    deque_cells[deque_count] = w.value;
                    deque_count++;
                end
            end
            CMD_REMOVE_END: begin
                if (deque_count == 0) r.status = ST_EMPTY;
                else deque_count--;
            end
            CMD_INSERT_FRONT: begin
                if (deque_count >= room) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = deque_count; i > 0; i--) deque_cells[i] = deque_cells[i-1];
                    deque_cells[0] = w.value;
                    deque_count++;
                end
            end
            CMD_REMOVE_FRONT: begin
                if (deque_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (i = 0; i + 1 < deque_count; i++) deque_cells[i] = deque_cells[i+1];
                    deque_count--;
                end
            end
            default: ;
        endcase
        if (w.cmd != CMD_DUMP) expected_results.push_back(r);
    endfunction

    // mostly back to back, sometimes short pauses, rarely long ones
    function automatic int unsigned pick_gap(bit enabled);
        int unsigned roll;
        if (!enabled) return 0;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 93) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic logic signed [WORD_W-1:0] random_word();
        case ($urandom_range(19))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return WORD_ONES;
            3: return '0;
            default: return $urandom();
        endcase
    endfunction

    task automatic report_mismatch(string field, longint want_v, longint got_v);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    endtask

    // sender: offer words from the pending queue
    always @(posedge aclk) begin
        logic       nxt_valid;
        bdeque_in_t nxt_data;
        nxt_valid = s_valid;
        nxt_data = s_data;
        if (s_valid && s_ready) begin
            apply_deque_command(s_data);
            nxt_valid = 1'b0;
            send_gap = pick_gap(send_idle_on);
        end
        if (aresetn && !nxt_valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_words.size() > 0) begin
                nxt_data = pending_words.pop_front();
                nxt_valid = 1'b1;
            end
        end
        s_valid <= nxt_valid;
        s_data <= nxt_data;
    end

    // receiver: check each result word against the oldest expectation
    always @(posedge aclk) begin
        bdeque_out_t want;
        if (m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with nothing expected: status %0d item %0d last %0d",
                         $time, m_data.status, m_data.item, m_data.last);
            end else begin
                want = expected_results.pop_front();
                if (m_data.status !== want.status)
                    report_mismatch("status", want.status, m_data.status);
                if (m_data.has_item !== want.has_item)
                    report_mismatch("has_item", want.has_item, m_data.has_item);
                if (m_data.item !== want.item)
                    report_mismatch("item", want.item, m_data.item);
                if (m_data.last !== want.last)
                    report_mismatch("last", want.last, m_data.last);
            end
            recv_gap = pick_gap(recv_idle_on);
        end
        // long hold-off asked for by the stimulus
        if (hold_ask != hold_done) begin
            hold_done = hold_ask;
            recv_hold = LONG_HOLD;
        end
        if (recv_hold > 0) begin
            recv_hold--;
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_bounded_array_deque: errors");
            $finish;
        end
    end

    task automatic queue_word(logic [CMD_W-1:0] cmd, logic signed [WORD_W-1:0] value);
        bdeque_in_t w;
        w.cmd = cmd;
        w.value = value;
        pending_words.push_back(w);
    endtask

    // only called while the block is idle
    task automatic write_limit(logic [LIMIT_W-1:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        deque_limit = v;
    endtask

    // sender pause until every result is back, then let the shifter settle
    task automatic wait_idle();
        while (pending_words.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_phase(int n, int add_pct, int rem_pct);
        int         roll;
        bdeque_in_t w;
        repeat (n) begin
            roll = $urandom_range(99);
            w.value = random_word();
            if (roll < 8)
                w.cmd = CMD_DUMP;
            else if (roll < 8 + add_pct)
                w.cmd = $urandom_range(1) ? CMD_APPEND : CMD_INSERT_FRONT;
            else if (roll < 8 + add_pct + rem_pct)
                w.cmd = $urandom_range(1) ? CMD_REMOVE_END : CMD_REMOVE_FRONT;
            else
                w.cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
            pending_words.push_back(w);
        end
    endtask

    // stimulus
    initial begin
        int k;
        int mode;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty list errors, extremes, all codes
        queue_word(CMD_DUMP, '0);
        queue_word(CMD_REMOVE_END, '0);
        queue_word(CMD_REMOVE_FRONT, WORD_ONES);
        queue_word(CMD_SPARE_LO, WORD_MAX);
        queue_word(CMD_APPEND, WORD_MAX);
        queue_word(CMD_APPEND, WORD_MIN);
        queue_word(CMD_INSERT_FRONT, WORD_ONES);
        queue_word(CMD_INSERT_FRONT, '0);
        queue_word(CMD_DUMP, WORD_ONES);
        queue_word(CMD_REMOVE_FRONT, '0);
        queue_word(CMD_REMOVE_END, '0);
        queue_word(CMD_DUMP, '0);
        queue_word(CMD_SPARE_MD, WORD_MIN);
        queue_word(CMD_SPARE_HI, WORD_ONES);
        queue_word(CMD_APPEND, 32'shAAAA_AAAA);
        queue_word(CMD_INSERT_FRONT, 32'sh5555_5555);
        queue_word(CMD_REMOVE_END, WORD_ONES);
        queue_word(CMD_REMOVE_FRONT, WORD_MAX);
        queue_word(CMD_DUMP, '0);
        queue_word(CMD_REMOVE_FRONT, '0);
        queue_word(CMD_REMOVE_FRONT, '0);
        queue_word(CMD_REMOVE_FRONT, '0);
        queue_word(CMD_REMOVE_END, '0);
        queue_word(CMD_DUMP, '0);
        wait_idle();

        // limit of one
        write_limit(5'd1);
        queue_word(CMD_APPEND, random_word());
        queue_word(CMD_APPEND, random_word());
        queue_word(CMD_INSERT_FRONT, random_word());
        queue_word(CMD_DUMP, '0);
        queue_word(CMD_REMOVE_FRONT, '0);
        queue_word(CMD_INSERT_FRONT, random_word());
        queue_word(CMD_INSERT_FRONT, random_word());
        queue_word(CMD_REMOVE_END, '0);
        queue_word(CMD_DUMP, '0);
        wait_idle();

        // limit of zero: always full
        write_limit(5'd0);
        queue_word(CMD_APPEND, random_word());
        queue_word(CMD_INSERT_FRONT, random_word());
        queue_word(CMD_REMOVE_END, '0);
        queue_word(CMD_REMOVE_FRONT, '0);
        queue_word(CMD_DUMP, '0);
        wait_idle();

        // limit past the storage saturates; receiver holds off while the list fills
        write_limit(5'd31);
        send_idle_on = 1'b0;
        hold_ask++;
        for (k = 0; k < 10; k++) queue_word(CMD_APPEND, random_word());
        for (k = 0; k < 7; k++) queue_word(CMD_INSERT_FRONT, random_word());
        queue_word(CMD_DUMP, '0);
        queue_word(CMD_APPEND, random_word());
        queue_word(CMD_DUMP, '0);
        wait_idle();
        send_idle_on = 1'b1;

        // limit lowered below the current count: entries stay, list counts as full
        write_limit(5'd4);
        queue_word(CMD_APPEND, random_word());
        queue_word(CMD_INSERT_FRONT, random_word());
        queue_word(CMD_DUMP, '0);
        for (k = 0; k < 12; k++)
            queue_word((k % 2) ? CMD_REMOVE_END : CMD_REMOVE_FRONT, '0);
        queue_word(CMD_APPEND, random_word());
        queue_word(CMD_REMOVE_END, '0);
        queue_word(CMD_INSERT_FRONT, random_word());
        queue_word(CMD_APPEND, random_word());
        queue_word(CMD_DUMP, '0);
        wait_idle();

        // random phases over assorted limits and idling patterns
        write_limit(5'd16);
        for (k = 0; k < 7; k++) begin
            if (k > 0) begin
                case ($urandom_range(9))
                    0: write_limit(5'd0);
                    1: write_limit(LIMIT_W'($urandom_range(31, 17)));
                    2: write_limit(5'd16);
                    default: write_limit(LIMIT_W'($urandom_range(16, 1)));
                endcase
            end
            send_idle_on = (k % 3) != 1;
            recv_idle_on = (k % 3) != 2;
            if (k == 3) hold_ask++;
            mode = $urandom_range(2);
            if (mode == 0) random_phase(30, 60, 29);
            else if (mode == 1) random_phase(30, 29, 60);
            else random_phase(30, 45, 44);
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("tb_bounded_array_deque: clean");
        end else begin
            $display("tb_bounded_array_deque: errors");
        end
        $finish;
    end

endmodule

// ----- bounded_array_deque.f -----
rtl/bdeque_pkg.sv
rtl/bdeque_ram.sv
rtl/bounded_array_deque.sv
tb/tb_bounded_array_deque.sv
